// ===== sv/lph_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types and constants of the linear probing hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

    localparam int unsigned TableDepthDef = 256;
    localparam int unsigned DataWidthDef  = 32;
    localparam int unsigned KeyWidthDef   = 64;
    localparam int unsigned PercentScale  = 100;
    localparam logic [6:0]  LoadReset     = 7'd75;

    typedef enum logic [1:0] {
        SLOT_UNUSED  = 2'd0,
        SLOT_USED    = 2'd1,
        SLOT_DELETED = 2'd2
    } t_slot;

    typedef enum logic [1:0] {
        OP_PUT  = 2'd0,
        OP_GET  = 2'd1,
        OP_DEL  = 2'd2,
        OP_NEXT = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EXISTS  = 3'd1,
        ST_NO_ITEM = 3'd2,
        ST_FULL    = 3'd3,
        ST_LAST    = 3'd4,
        ST_EMPTY   = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_PROBE_RD,
        S_PROBE_EV,
        S_SCAN_RD,
        S_SCAN_EV,
        S_NEXT_RD,
        S_NEXT_EV,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== sv/lph_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lph_mem
// Slot store: status, key and data arrays with registered reads.
// ----------------------------------------------------------------------------
module lph_mem
    import lph_pkg::*;
#(
    parameter int unsigned DATA_WIDTH  = DataWidthDef,
    parameter int unsigned KEY_WIDTH   = KeyWidthDef,
    localparam int unsigned TABLE_DEPTH = TableDepthDef,
    localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
    input  wire logic                  i_clk,
    input  wire logic [AW-1:0]         i_rd_addr,
    input  wire logic                  i_st_we,
    input  wire logic [AW-1:0]         i_wr_addr,
    input  wire t_slot                 i_st_wdata,
    input  wire logic                  i_kv_we,
    input  wire logic [KEY_WIDTH-1:0]  i_key_wdata,
    input  wire logic [DATA_WIDTH-1:0] i_val_wdata,
    output t_slot                      o_st_rdata,
    output logic [KEY_WIDTH-1:0]       o_key_rdata,
    output logic [DATA_WIDTH-1:0]      o_val_rdata
);

    t_slot                 r_st  [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0]  r_key [TABLE_DEPTH];
    logic [DATA_WIDTH-1:0] r_val [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_st_we) begin
            r_st[i_wr_addr] <= i_st_wdata;
        end
        o_st_rdata <= r_st[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_kv_we) begin
            r_key[i_wr_addr] <= i_key_wdata;
            r_val[i_wr_addr] <= i_val_wdata;
        end
        o_key_rdata <= r_key[i_rd_addr];
        o_val_rdata <= r_val[i_rd_addr];
    end

endmodule
`default_nettype wire

// ===== sv/lph_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lph_ctrl
// Operation sequencer: probes, scans and updates the slot store.
// ----------------------------------------------------------------------------
module lph_ctrl
    import lph_pkg::*;
#(
    parameter int unsigned DATA_WIDTH  = DataWidthDef,
    parameter int unsigned KEY_WIDTH   = KeyWidthDef,
    // depth is a power of two: the start slot is the low hash bits
    localparam int unsigned TABLE_DEPTH = TableDepthDef,
    localparam int unsigned AW = $clog2(TABLE_DEPTH),
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    input  wire logic [1:0]            i_kind,
    input  wire logic [63:0]           i_key,
    input  wire logic [31:0]           i_key_hash,
    input  wire logic [31:0]           i_value,
    input  wire logic [6:0]            i_max_load,
    output logic                       busy,
    output logic                       o_done,
    output logic [2:0]                 o_status,
    output logic [31:0]                o_found_value,
    output logic [63:0]                o_found_key,
    output logic [CW-1:0]              o_occ,
    output logic [AW-1:0]              o_rd_addr,
    output logic                       o_st_we,
    output logic [AW-1:0]              o_wr_addr,
    output t_slot                      o_st_wdata,
    output logic                       o_kv_we,
    output logic [KEY_WIDTH-1:0]       o_key_wdata,
    output logic [DATA_WIDTH-1:0]      o_val_wdata,
    input  wire t_slot                 i_st_rdata,
    input  wire logic [KEY_WIDTH-1:0]  i_key_rdata,
    input  wire logic [DATA_WIDTH-1:0] i_val_rdata
);

    localparam int unsigned PW = CW + 7;

    t_state                r_state, n_state;
    t_op                   r_op, n_op;
    logic [KEY_WIDTH-1:0]  r_key, n_key;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [AW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [CW-1:0]         r_occ, n_occ;
    logic [CW-1:0]         r_iter, n_iter;
    logic                  r_wrap, n_wrap;
    logic [2:0]            r_status, n_status;
    logic [31:0]           r_fval, n_fval;
    logic [63:0]           r_fkey, n_fkey;

    logic [PW-1:0] w_load_num;
    logic [PW-1:0] w_limit;
    logic          w_last_idx;

    // occupied*100/depth >= limit  <=>  occupied*100 >= limit*depth
    assign w_load_num = PW'(r_occ) * PW'(PercentScale);
    assign w_limit    = PW'(i_max_load) * PW'(TABLE_DEPTH);
    assign w_last_idx = (r_idx == AW'(TABLE_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_occ   <= '0;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_occ   <= n_occ;
            r_iter  <= n_iter;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_val    <= n_val;
        r_cnt    <= n_cnt;
        r_wrap   <= n_wrap;
        r_status <= n_status;
        r_fval   <= n_fval;
        r_fkey   <= n_fkey;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_val       = r_val;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_occ       = r_occ;
        n_iter      = r_iter;
        n_wrap      = r_wrap;
        n_status    = r_status;
        n_fval      = r_fval;
        n_fkey      = r_fkey;
        o_rd_addr   = r_idx;
        o_st_we     = 1'b0;
        o_wr_addr   = r_idx;
        o_st_wdata  = SLOT_UNUSED;
        o_kv_we     = 1'b0;
        o_key_wdata = r_key;
        o_val_wdata = r_val;
        busy        = 1'b1;
        o_done      = 1'b0;
        case (r_state)
            S_CLEAR: begin
                // sweep every status entry to unused after reset
                o_st_we = 1'b1;
                n_idx   = r_idx + 1'b1;
                if (w_last_idx) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    n_op     = t_op'(i_kind);
                    n_key    = i_key[KEY_WIDTH-1:0];
                    n_val    = i_value[DATA_WIDTH-1:0];
                    n_idx    = i_key_hash[AW-1:0];
                    n_cnt    = '0;
                    n_wrap   = 1'b0;
                    n_status = ST_OK;
                    n_fval   = '0;
                    n_fkey   = '0;
                    n_state  = S_LOAD;
                end
            end
            S_LOAD: begin
                case (r_op)
                    OP_PUT, OP_GET, OP_DEL: begin
                        n_state = S_PROBE_RD;
                    end
                    default: begin
                        if (r_occ == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            // iter position equal to depth restarts at slot 0
                            n_idx = (r_iter >= CW'(TABLE_DEPTH)) ? '0 : r_iter[AW-1:0];
                            n_wrap  = (r_iter >= CW'(TABLE_DEPTH)) || (r_iter == '0);
                            n_state = S_SCAN_RD;
                        end
                    end
                endcase
                if (r_op == OP_PUT && w_load_num >= w_limit) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end
            end
            S_PROBE_RD: begin
                n_state = S_PROBE_EV;
            end
            S_PROBE_EV: begin
                n_state = S_PROBE_RD;
                if (r_op == OP_PUT) begin
                    if (i_st_rdata != SLOT_USED) begin
                        o_st_we    = 1'b1;
                        o_st_wdata = SLOT_USED;
                        o_kv_we    = 1'b1;
                        if (r_occ < CW'(TABLE_DEPTH)) begin
                            n_occ = r_occ + 1'b1;
                        end
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end else if (i_key_rdata == r_key) begin
                        n_status = ST_EXISTS;
                        n_state  = S_DONE;
                    end
                end else begin
                    if (i_st_rdata == SLOT_UNUSED) begin
                        n_status = ST_NO_ITEM;
                        n_state  = S_DONE;
                    end else if (i_st_rdata == SLOT_USED && i_key_rdata == r_key) begin
                        if (r_op == OP_GET) begin
                            n_fval = 32'(i_val_rdata);
                        end else begin
                            o_st_we    = 1'b1;
                            o_st_wdata = SLOT_DELETED;
                        end
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end
                end
                if (n_state == S_PROBE_RD) begin
                    n_idx = r_idx + 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == CW'(TABLE_DEPTH - 1)) begin
                        n_status = (r_op == OP_PUT) ? ST_FULL : ST_NO_ITEM;
                        n_state  = S_DONE;
                    end
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                if (i_st_rdata == SLOT_USED) begin
                    n_fkey  = 64'(i_key_rdata);
                    n_fval  = 32'(i_val_rdata);
                    n_state = S_NEXT_RD;
                    if (w_last_idx) begin
                        n_status = ST_LAST;
                        n_iter   = '0;
                        n_state  = S_DONE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else if (w_last_idx) begin
                    if (r_wrap) begin
                        n_status = ST_EMPTY;
                        n_iter   = '0;
                        n_state  = S_DONE;
                    end else begin
                        // wrap once to slot 0
                        n_wrap  = 1'b1;
                        n_idx   = '0;
                        n_state = S_SCAN_RD;
                    end
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_NEXT_RD: begin
                n_state = S_NEXT_EV;
            end
            S_NEXT_EV: begin
                if (i_st_rdata == SLOT_USED) begin
                    n_iter  = CW'(r_idx);
                    n_state = S_DONE;
                end else if (w_last_idx) begin
                    n_status = ST_LAST;
                    n_iter   = '0;
                    n_state  = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_NEXT_RD;
                end
            end
            S_DONE: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_status      = r_status;
    assign o_found_value = r_fval;
    assign o_found_key   = r_fkey;
    assign o_occ         = r_occ;

endmodule
`default_nettype wire

// ===== sv/linear_probe_hash_table_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Open-addressing hash table with linear probing and tombstones.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with i_kind/i_key/i_key_hash/i_value while busy is low; the
//   word is taken on that edge and busy rises until the result is out.
//   One result per word: o_valid is high for exactly one cycle with o_status,
//   o_found_value and o_found_key. The receiver cannot stall.
//   Put/get/delete probe from the hash slot and next scans from the
//   iterator, each with one read-then-evaluate pass per slot over the
//   registered slot memory.
//   Reset: i_rst_n low clears the occupied count and the iterator; then a
//   clearing pass marks every slot unused, with busy held high.
//   i_cfg_we writes max_load_percent (reset 75); the user must write it
//   only at an idle edge, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top
    import lph_pkg::*;
#(
    parameter int unsigned DATA_WIDTH  = DataWidthDef,
    parameter int unsigned KEY_WIDTH   = KeyWidthDef,
    localparam int unsigned TABLE_DEPTH = TableDepthDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_kind,
    input  wire logic [63:0] i_key,
    input  wire logic [31:0] i_key_hash,
    input  wire logic [31:0] i_value,
    input  wire logic        i_cfg_we,
    input  wire logic [6:0]  i_cfg_wdata,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic [31:0]      o_found_value,
    output logic [63:0]      o_found_key
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    logic [6:0]            r_max_load;
    logic [AW-1:0]         w_rd_addr, w_wr_addr;
    logic                  w_st_we, w_kv_we;
    t_slot                 w_st_wdata, w_st_rdata;
    logic [KEY_WIDTH-1:0]  w_key_wdata, w_key_rdata;
    logic [DATA_WIDTH-1:0] w_val_wdata, w_val_rdata;
    logic [CW-1:0]         w_occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_load <= LoadReset;
        end else if (i_cfg_we) begin
            r_max_load <= i_cfg_wdata;
        end
    end

    lph_ctrl #(
        .DATA_WIDTH  (DATA_WIDTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_kind        (i_kind),
        .i_key         (i_key),
        .i_key_hash    (i_key_hash),
        .i_value       (i_value),
        .i_max_load    (r_max_load),
        .busy          (busy),
        .o_done        (o_valid),
        .o_status      (o_status),
        .o_found_value (o_found_value),
        .o_found_key   (o_found_key),
        .o_occ         (w_occ),
        .o_rd_addr     (w_rd_addr),
        .o_st_we       (w_st_we),
        .o_wr_addr     (w_wr_addr),
        .o_st_wdata    (w_st_wdata),
        .o_kv_we       (w_kv_we),
        .o_key_wdata   (w_key_wdata),
        .o_val_wdata   (w_val_wdata),
        .i_st_rdata    (w_st_rdata),
        .i_key_rdata   (w_key_rdata),
        .i_val_rdata   (w_val_rdata)
    );

    lph_mem #(
        .DATA_WIDTH  (DATA_WIDTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rd_addr   (w_rd_addr),
        .i_st_we     (w_st_we),
        .i_wr_addr   (w_wr_addr),
        .i_st_wdata  (w_st_wdata),
        .i_kv_we     (w_kv_we),
        .i_key_wdata (w_key_wdata),
        .i_val_wdata (w_val_wdata),
        .o_st_rdata  (w_st_rdata),
        .o_key_rdata (w_key_rdata),
        .o_val_rdata (w_val_rdata)
    );

`ifndef SYNTHESIS
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_occ <= CW'(TABLE_DEPTH))
        else $error("occupied count above depth");

    a_occ_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> w_occ >= $past(w_occ))
        else $error("occupied count decreased");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result while idle");

    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK && o_status != ST_LAST |-> o_found_value == '0)
        else $error("data on failed operation");
`endif

endmodule
`default_nettype wire
